@@ sv/pcdrb_pkg.sv @@
// Package for the per-channel delay ring buffer: operation codes,
// configuration register indexes and fixed field widths.
// No dependencies; used by the interfaces and the top level.
package pcdrb_pkg;

  localparam int unsigned MaxChannels = 1024;
  localparam int unsigned MaxDepth    = 4096;
  localparam int unsigned SampleBits  = 8;

  localparam int unsigned ChanW    = 10;
  localparam int unsigned DelayW   = 12;
  localparam int unsigned FillW    = 13;
  localparam int unsigned CfgW     = 13;
  localparam int unsigned ChanCfgW = 11;
  localparam int unsigned CfgIdxW  = 1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_WR_DLY = 2'd1,
    OP_WR_RAW = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHANNELS = 1'b0,
    CFG_DEPTH    = 1'b1
  } cfg_idx_e;

endpackage

@@ sv/pcdrb_if.sv @@
// Valid/ready channel interfaces for the delay ring buffer: the input item
// channel and the read result channel. Depends on pcdrb_pkg.
interface pcdrb_in_if #(
  parameter int unsigned SAMPLE_BITS = pcdrb_pkg::SampleBits
);
  logic                          valid;
  logic                          ready;
  pcdrb_pkg::op_e                op;
  logic [pcdrb_pkg::ChanW-1:0]   channel;
  logic [SAMPLE_BITS-1:0]        sample_value;
  logic [pcdrb_pkg::DelayW-1:0]  delay_value;
  logic                          row_end;

  modport source (output valid, op, channel, sample_value, delay_value, row_end,
                  input ready);
  modport sink   (input valid, op, channel, sample_value, delay_value, row_end,
                  output ready);
endinterface

interface pcdrb_out_if #(
  parameter int unsigned SAMPLE_BITS = pcdrb_pkg::SampleBits
);
  logic                         valid;
  logic                         ready;
  logic [SAMPLE_BITS-1:0]       read_value;
  logic [pcdrb_pkg::ChanW-1:0]  read_channel;
  logic [pcdrb_pkg::FillW-1:0]  fill_rows;
  logic                         last;

  modport source (output valid, read_value, read_channel, fill_rows, last,
                  input ready);
  modport sink   (input valid, read_value, read_channel, fill_rows, last,
                  output ready);
endinterface

@@ sv/pcdrb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module pcdrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read during write to the same address returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/per_channel_delay_ring_buffer.sv @@
// Per-channel delay ring buffer: sample store and delay table in RAMs.
// Depends on pcdrb_pkg, pcdrb_if and pcdrb_ram.
// Throughput: one item per cycle unless clearing or a stage 1 read waits
// on the output; the sample RAM's single write and single read port carry
// one access each cycle. A read result passes stage 1 and the output
// register. Reset, and any configuration write, starts a clearing pass
// over active_depth * active_channels entries, one per cycle; ready low.
module per_channel_delay_ring_buffer #(
  parameter int unsigned MAX_CHANNELS = pcdrb_pkg::MaxChannels,
  parameter int unsigned MAX_DEPTH    = pcdrb_pkg::MaxDepth,
  parameter int unsigned SAMPLE_BITS  = pcdrb_pkg::SampleBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pcdrb_in_if.sink                    in_i,
  pcdrb_out_if.source                 out_o,
  input  logic                        cfg_we_i,
  input  pcdrb_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [pcdrb_pkg::CfgW-1:0]  cfg_data_i
);

  import pcdrb_pkg::*;

  localparam int unsigned RowW    = $clog2(MAX_DEPTH);
  localparam int unsigned ChW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned AcW     = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned AdW     = $clog2(MAX_DEPTH + 1);
  localparam int unsigned StoreAw = RowW + ChW;
  localparam int unsigned StoreDepth = 1 << StoreAw;

  // Configuration and pointer state
  logic [AcW-1:0]  act_ch_q, act_ch_d;
  logic [AdW-1:0]  act_depth_q, act_depth_d;
  logic [RowW-1:0] wr_row_q, wr_row_d;
  logic [RowW-1:0] rd_row_q, rd_row_d;
  logic [AdW-1:0]  fill_q, fill_d;
  logic            clr_q, clr_d;
  logic [RowW-1:0] clr_row_q, clr_row_d;
  logic [ChW-1:0]  clr_ch_q, clr_ch_d;

  // Stage 1: item waiting on RAM read data
  logic                   s1_v_q;
  op_e                    s1_op_q;
  logic [ChanW-1:0]       s1_ch_q;
  logic                   s1_ok_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic [RowW-1:0]        s1_wrow_q;
  logic                   s1_last_q;
  logic [AdW-1:0]         s1_fill_q;
  logic                   byp_q;
  logic [SAMPLE_BITS-1:0] byp_data_q;

  // Output register
  logic                   out_v_q;
  logic [SAMPLE_BITS-1:0] out_val_q;
  logic [ChanW-1:0]       out_ch_q;
  logic [AdW-1:0]         out_fill_q;
  logic                   out_last_q;

  logic                   ch_ok, s1_stall, in_ready, accept;
  logic [ChW-1:0]         ch_idx;
  logic [RowW:0]          wr_inc, rd_inc;
  logic [RowW-1:0]        wr_next, rd_next;
  logic [RowW-1:0]        dly_clamped;
  logic [AcW-1:0]         cfg_ch;
  logic [AdW-1:0]         cfg_depth;
  logic                   clr_last_ch, clr_last_row;

  logic                   dly_we, dly_re;
  logic [ChW-1:0]         dly_waddr;
  logic [RowW-1:0]        dly_wdata, dly_rdata;
  logic                   st_we, st_re;
  logic [StoreAw-1:0]     st_waddr, st_raddr;
  logic [SAMPLE_BITS-1:0] st_wdata, st_rdata;

  logic [RowW-1:0]        s1_d;
  logic [RowW:0]          s1_diff;
  logic [RowW-1:0]        s1_row;
  logic                   s1_we;
  logic [StoreAw-1:0]     s1_addr;
  logic                   byp_hit;
  logic [SAMPLE_BITS-1:0] s1_rval;

  // ---------------------------------------------------------------- input side
  assign ch_ok  = (32'(in_i.channel) < 32'(act_ch_q)) && (32'(in_i.channel) < MAX_CHANNELS);
  assign ch_idx = ChW'(in_i.channel);

  assign s1_stall = s1_v_q && (s1_op_q == OP_READ) && out_v_q && !out_o.ready;
  assign in_ready = !clr_q && !s1_stall;
  assign accept   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  assign wr_inc  = {1'b0, wr_row_q} + (RowW+1)'(1);
  assign rd_inc  = {1'b0, rd_row_q} + (RowW+1)'(1);
  assign wr_next = (32'(wr_inc) >= 32'(act_depth_q)) ? '0 : wr_inc[RowW-1:0];
  assign rd_next = (32'(rd_inc) >= 32'(act_depth_q)) ? '0 : rd_inc[RowW-1:0];

  assign dly_clamped = (32'(in_i.delay_value) >= 32'(act_depth_q)) ?
                       RowW'(act_depth_q - AdW'(1)) : RowW'(in_i.delay_value);

  // Register writes: 0 is taken as 1, larger values saturate
  always_comb begin
    logic [ChanCfgW-1:0] chv;
    chv = cfg_data_i[ChanCfgW-1:0];
    if (chv == '0) begin
      cfg_ch = AcW'(1);
    end else if (32'(chv) > MAX_CHANNELS) begin
      cfg_ch = AcW'(MAX_CHANNELS);
    end else begin
      cfg_ch = AcW'(chv);
    end
    if (cfg_data_i == '0) begin
      cfg_depth = AdW'(1);
    end else if (32'(cfg_data_i) > MAX_DEPTH) begin
      cfg_depth = AdW'(MAX_DEPTH);
    end else begin
      cfg_depth = AdW'(cfg_data_i);
    end
  end

  assign clr_last_ch  = (32'(clr_ch_q) + 32'd1) == 32'(act_ch_q);
  assign clr_last_row = (32'(clr_row_q) + 32'd1) == 32'(act_depth_q);

  always_comb begin
    act_ch_d    = act_ch_q;
    act_depth_d = act_depth_q;
    wr_row_d    = wr_row_q;
    rd_row_d    = rd_row_q;
    fill_d      = fill_q;
    clr_d       = clr_q;
    clr_row_d   = clr_row_q;
    clr_ch_d    = clr_ch_q;

    if (clr_q) begin
      if (clr_last_ch) begin
        clr_ch_d = '0;
        if (clr_last_row) begin
          clr_d = 1'b0;
        end else begin
          clr_row_d = clr_row_q + RowW'(1);
        end
      end else begin
        clr_ch_d = clr_ch_q + ChW'(1);
      end
    end

    if (accept && in_i.row_end) begin
      case (in_i.op)
        OP_WR_DLY, OP_WR_RAW: begin
          wr_row_d = wr_next;
          if (32'(fill_q) < 32'(act_depth_q)) fill_d = fill_q + AdW'(1);
        end
        OP_READ: begin
          rd_row_d = rd_next;
          if (fill_q != '0) fill_d = fill_q - AdW'(1);
        end
        default: ;
      endcase
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CHANNELS: act_ch_d    = cfg_ch;
        CFG_DEPTH:    act_depth_d = cfg_depth;
        default: ;
      endcase
      wr_row_d  = '0;
      rd_row_d  = '0;
      fill_d    = '0;
      clr_d     = 1'b1;
      clr_row_d = '0;
      clr_ch_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_ch_q    <= AcW'(MAX_CHANNELS);
      act_depth_q <= AdW'(MAX_DEPTH);
      wr_row_q    <= '0;
      rd_row_q    <= '0;
      fill_q      <= '0;
      clr_q       <= 1'b1;
      clr_row_q   <= '0;
      clr_ch_q    <= '0;
    end else begin
      act_ch_q    <= act_ch_d;
      act_depth_q <= act_depth_d;
      wr_row_q    <= wr_row_d;
      rd_row_q    <= rd_row_d;
      fill_q      <= fill_d;
      clr_q       <= clr_d;
      clr_row_q   <= clr_row_d;
      clr_ch_q    <= clr_ch_d;
    end
  end

  // -------------------------------------------------------------- delay table
  assign dly_we    = clr_q ? (clr_row_q == '0) : (accept && (in_i.op == OP_LOAD) && ch_ok);
  assign dly_waddr = clr_q ? clr_ch_q : ch_idx;
  assign dly_wdata = clr_q ? '0 : dly_clamped;
  assign dly_re    = accept && (in_i.op == OP_WR_DLY);

  pcdrb_ram #(
    .WIDTH (RowW),
    .DEPTH (MAX_CHANNELS)
  ) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (dly_we),
    .waddr_i (dly_waddr),
    .wdata_i (dly_wdata),
    .re_i    (dly_re),
    .raddr_i (ch_idx),
    .rdata_o (dly_rdata)
  );

  // ------------------------------------------------------- stage 1 write row
  assign s1_d    = (32'(dly_rdata) >= 32'(act_depth_q)) ?
                   RowW'(act_depth_q - AdW'(1)) : dly_rdata;
  assign s1_diff = {1'b0, s1_wrow_q} - {1'b0, s1_d};
  always_comb begin
    if (s1_op_q == OP_WR_DLY) begin
      s1_row = s1_diff[RowW] ? RowW'(s1_diff + (RowW+1)'(act_depth_q)) : s1_diff[RowW-1:0];
    end else begin
      s1_row = s1_wrow_q;
    end
  end
  assign s1_we   = s1_v_q && ((s1_op_q == OP_WR_DLY) || (s1_op_q == OP_WR_RAW)) && s1_ok_q;
  assign s1_addr = {s1_row, ChW'(s1_ch_q)};

  // ------------------------------------------------------------- sample store
  assign st_we    = clr_q || s1_we;
  assign st_waddr = clr_q ? {clr_row_q, clr_ch_q} : s1_addr;
  assign st_wdata = clr_q ? '0 : s1_sample_q;
  assign st_re    = accept && (in_i.op == OP_READ);
  assign st_raddr = {rd_row_q, ch_idx};

  // A read issued while stage 1 writes the same entry takes the new sample
  assign byp_hit = st_re && s1_we && (s1_addr == st_raddr);

  pcdrb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (StoreDepth)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      byp_q  <= 1'b0;
    end else if (!s1_stall) begin
      s1_v_q <= accept;
      byp_q  <= byp_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!s1_stall) begin
      s1_op_q     <= in_i.op;
      s1_ch_q     <= in_i.channel;
      s1_ok_q     <= ch_ok;
      s1_sample_q <= SAMPLE_BITS'(in_i.sample_value);
      s1_wrow_q   <= wr_row_q;
      s1_last_q   <= in_i.row_end;
      s1_fill_q   <= fill_d;
      byp_data_q  <= s1_sample_q;
    end
  end

  // ---------------------------------------------------------- output register
  assign s1_rval = !s1_ok_q ? '0 : (byp_q ? byp_data_q : st_rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || out_o.ready) begin
      out_v_q <= s1_v_q && (s1_op_q == OP_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_o.ready) begin
      out_val_q  <= s1_rval;
      out_ch_q   <= s1_ch_q;
      out_fill_q <= s1_fill_q;
      out_last_q <= s1_last_q;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.read_value   = out_val_q;
  assign out_o.read_channel = out_ch_q;
  assign out_o.fill_rows    = FillW'(out_fill_q);
  assign out_o.last         = out_last_q;

  // --------------------------------------------------------------- assertions
  a_clr_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !in_i.ready)
    else $error("item accepted during clearing pass");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(act_depth_q))
    else $error("fill count above active depth");

  a_rows_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(wr_row_q) < 32'(act_depth_q)) && (32'(rd_row_q) < 32'(act_depth_q)))
    else $error("row pointer outside active depth");

  a_bypass_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_q |-> (s1_v_q && (s1_op_q == OP_READ)))
    else $error("store bypass set without a pending read");

  a_stall_keeps_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_stall |=> (s1_v_q && (s1_op_q == OP_READ)))
    else $error("stalled read lost from stage 1");

endmodule
